@@ hw/rtl/qau_pkg.sv @@
`timescale 1ns / 1ps

package qau_pkg;

  localparam int WORD_BITS   = 32;
  localparam int FRAC_BITS   = 28;
  localparam int TOL_BITS    = 29;
  localparam int ACC_BITS    = 68;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [TOL_BITS-1:0] TOL_RESET = TOL_BITS'(268);

  typedef logic signed [WORD_BITS-1:0] word_t;

  localparam word_t WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam word_t WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};
  localparam logic [WORD_BITS:0] ONE_Q = (WORD_BITS+1)'(1) << FRAC_BITS;

  // request codes on the input port
  localparam logic [2:0] REQ_MUL    = 3'd0;
  localparam logic [2:0] REQ_CONJ   = 3'd1;
  localparam logic [2:0] REQ_NORM   = 3'd2;
  localparam logic [2:0] REQ_MAT    = 3'd3;
  localparam logic [2:0] REQ_APPROX = 3'd4;
  localparam logic [2:0] REQ_UNIT   = 3'd5;

  // operand slots
  localparam logic [2:0] SRC_AX = 3'd0;
  localparam logic [2:0] SRC_AY = 3'd1;
  localparam logic [2:0] SRC_AZ = 3'd2;
  localparam logic [2:0] SRC_AW = 3'd3;

  typedef enum logic [2:0] {
    OP_MUL, OP_CONJ, OP_NORM, OP_MAT, OP_APPROX, OP_UNIT, OP_BAD
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MAC, ST_DRAIN, ST_ROUND, ST_SQSUM, ST_SQRT, ST_SQDONE,
    ST_DIV, ST_DIVRND, ST_EMIT
  } state_t;

  typedef struct packed {
    logic [2:0] req_type;
    word_t      a_x;
    word_t      a_y;
    word_t      a_z;
    word_t      a_w;
    word_t      b_x;
    word_t      b_y;
    word_t      b_z;
    word_t      b_w;
  } in_word_t;

  typedef struct packed {
    word_t res_a;
    word_t res_b;
    word_t res_c;
    word_t res_d;
    logic  test_flag;
    logic  sat_flag;
    logic  last;
  } out_word_t;

  typedef struct packed {
    op_t             op;
    word_t [7:0]     opnd;
  } item_t;

  typedef struct packed {
    logic [2:0] src1;
    logic [2:0] src2;
    logic       neg;
    logic       dbl;
    logic       en;
  } lane_ctl_t;

  typedef struct packed {
    word_t val;
    logic  sat;
  } rnd_t;

  // add half, drop fraction, saturate to word
  function automatic rnd_t rnd_sat(input logic signed [ACC_BITS-1:0] acc);
    logic signed [ACC_BITS-1:0] t;
    logic [ACC_BITS-FRAC_BITS-1:0] sh;
    logic [ACC_BITS-FRAC_BITS-WORD_BITS:0] top;
    rnd_t r;
    t   = acc + (ACC_BITS'(1) << (FRAC_BITS - 1));
    sh  = t[ACC_BITS-1:FRAC_BITS];
    top = sh[ACC_BITS-FRAC_BITS-1:WORD_BITS-1];
    if ((top == '0) || (top == '1)) begin
      r.val = sh[WORD_BITS-1:0];
      r.sat = 1'b0;
    end else begin
      r.val = sh[ACC_BITS-FRAC_BITS-1] ? WORD_MIN : WORD_MAX;
      r.sat = 1'b1;
    end
    return r;
  endfunction

  function automatic logic [WORD_BITS:0] abs_w(input word_t v);
    logic signed [WORD_BITS:0] e;
    e = (WORD_BITS+1)'(v);
    return v[WORD_BITS-1] ? -e : e;
  endfunction

  // product lane r, step k: a[(3-r)^k] * b[k]
  function automatic lane_ctl_t mul_ctl(input logic [1:0] lane, input logic [1:0] k,
                                        input logic cb);
    lane_ctl_t c;
    logic [3:0] ng;
    unique case (lane)
      2'd0: ng = 4'b0100;
      2'd1: ng = 4'b0001;
      2'd2: ng = 4'b0010;
      default: ng = 4'b0111;
    endcase
    c.src1 = {1'b0, (~lane) ^ k};
    c.src2 = {1'b1, k};
    c.neg  = ng[k] ^ (cb & (k != 2'd3));
    c.dbl  = 1'b0;
    c.en   = 1'b1;
    return c;
  endfunction

  // rotation matrix entry e (row-major), step k
  function automatic lane_ctl_t mat_ctl(input logic [3:0] e, input logic [1:0] k);
    lane_ctl_t c;
    c.src1 = SRC_AX;
    c.src2 = SRC_AX;
    c.neg  = 1'b0;
    c.dbl  = 1'b1;
    c.en   = ~k[1];
    unique case (e)
      4'd0, 4'd4, 4'd8: begin
        c.src1 = {1'b0, k};
        c.src2 = {1'b0, k};
        c.dbl  = 1'b0;
        c.en   = 1'b1;
        if (e == 4'd0) begin
          c.neg = (k == 2'd1) || (k == 2'd2);
        end else if (e == 4'd4) begin
          c.neg = (k == 2'd0) || (k == 2'd2);
        end else begin
          c.neg = (k == 2'd0) || (k == 2'd1);
        end
      end
      4'd1: begin
        c.src1 = k[0] ? SRC_AZ : SRC_AX;
        c.src2 = k[0] ? SRC_AW : SRC_AY;
      end
      4'd2: begin
        c.src1 = k[0] ? SRC_AY : SRC_AX;
        c.src2 = k[0] ? SRC_AW : SRC_AZ;
        c.neg  = k[0];
      end
      4'd3: begin
        c.src1 = k[0] ? SRC_AZ : SRC_AX;
        c.src2 = k[0] ? SRC_AW : SRC_AY;
        c.neg  = k[0];
      end
      4'd5: begin
        c.src1 = k[0] ? SRC_AX : SRC_AY;
        c.src2 = k[0] ? SRC_AW : SRC_AZ;
      end
      4'd6: begin
        c.src1 = k[0] ? SRC_AY : SRC_AX;
        c.src2 = k[0] ? SRC_AW : SRC_AZ;
      end
      4'd7: begin
        c.src1 = k[0] ? SRC_AX : SRC_AY;
        c.src2 = k[0] ? SRC_AW : SRC_AZ;
        c.neg  = k[0];
      end
      default: c.en = 1'b0;
    endcase
    return c;
  endfunction

endpackage

@@ hw/rtl/qau_front.sv @@
`timescale 1ns / 1ps

module qau_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  qau_pkg::in_word_t  in_data,
  output logic               push_valid,
  input  logic               push_ready,
  output qau_pkg::item_t     push_item
);

  logic           hold_valid_r;
  qau_pkg::item_t hold_r;
  qau_pkg::item_t item_nxt;

  assign in_ready   = !hold_valid_r || push_ready;
  assign push_valid = hold_valid_r;
  assign push_item  = hold_r;

  always_comb begin
    unique case (in_data.req_type)
      qau_pkg::REQ_MUL:    item_nxt.op = qau_pkg::OP_MUL;
      qau_pkg::REQ_CONJ:   item_nxt.op = qau_pkg::OP_CONJ;
      qau_pkg::REQ_NORM:   item_nxt.op = qau_pkg::OP_NORM;
      qau_pkg::REQ_MAT:    item_nxt.op = qau_pkg::OP_MAT;
      qau_pkg::REQ_APPROX: item_nxt.op = qau_pkg::OP_APPROX;
      qau_pkg::REQ_UNIT:   item_nxt.op = qau_pkg::OP_UNIT;
      default:             item_nxt.op = qau_pkg::OP_BAD;
    endcase
    item_nxt.opnd[0] = in_data.a_x;
    item_nxt.opnd[1] = in_data.a_y;
    item_nxt.opnd[2] = in_data.a_z;
    item_nxt.opnd[3] = in_data.a_w;
    item_nxt.opnd[4] = in_data.b_x;
    item_nxt.opnd[5] = in_data.b_y;
    item_nxt.opnd[6] = in_data.b_z;
    item_nxt.opnd[7] = in_data.b_w;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
    end else if (in_ready) begin
      hold_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold_r <= item_nxt;
    end
  end

endmodule

@@ hw/rtl/qau_queue.sv @@
`timescale 1ns / 1ps

module qau_queue #(
  parameter int DEPTH = qau_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  output logic           push_ready,
  input  qau_pkg::item_t push_item,
  output logic           pop_valid,
  input  logic           pop,
  output qau_pkg::item_t pop_item
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  qau_pkg::item_t   mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             do_push, do_pop;

  assign push_ready = (cnt_r != CNT_W'(DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_item   = mem[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_item;
    end
  end

endmodule

@@ hw/rtl/qau_back.sv @@
`timescale 1ns / 1ps

module qau_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              q_valid,
  output logic                              q_pop,
  input  qau_pkg::item_t                    q_item,
  input  logic [qau_pkg::TOL_BITS-1:0]      tol,
  output logic                              out_valid,
  input  logic                              out_ready,
  output qau_pkg::out_word_t                out_data
);

  localparam int AB = qau_pkg::ACC_BITS;
  localparam int WB = qau_pkg::WORD_BITS;
  localparam int FB = qau_pkg::FRAC_BITS;

  qau_pkg::state_t    state_r, state_nxt;
  qau_pkg::item_t     item_r;
  logic [1:0]         k_r, row_r;
  logic [4:0]         cnt_r;

  qau_pkg::lane_ctl_t ctl [4];
  qau_pkg::lane_ctl_t mac_ctl_r [4];
  logic               mac_vld_r, mac_first_r;
  logic signed [2*WB-1:0] prod_r [4];
  logic signed [AB-1:0]   acc_r [4];

  qau_pkg::word_t     res_r [4];
  logic               sat_r;

  logic [63:0]        sq_s_r;
  logic [35:0]        sq_rem_r;
  logic [32:0]        root_r;
  logic [60:0]        drem_r [4];
  logic [FB-1:0]      dq_r [4];

  logic               out_valid_r;
  qau_pkg::out_word_t out_r, out_nxt;

  logic               sq_mode, mac_last, out_free, emit;
  logic [64:0]        sq_sum;
  logic [35:0]        sq_shift, sq_trial;

  assign sq_mode  = (item_r.op == qau_pkg::OP_NORM) || (item_r.op == qau_pkg::OP_UNIT);
  assign mac_last = sq_mode || (k_r == 2'd3);
  assign out_free = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign sq_sum = 65'(acc_r[0][63:0]) + 65'(acc_r[1][63:0])
                + 65'(acc_r[2][63:0]) + 65'(acc_r[3][63:0]);
  assign sq_shift = {sq_rem_r[33:0], sq_s_r[63:62]};
  assign sq_trial = {2'b00, root_r[31:0], 2'b01};

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      qau_pkg::ST_IDLE: begin
        if (q_valid) begin
          if (q_item.op == qau_pkg::OP_CONJ || q_item.op == qau_pkg::OP_BAD) begin
            state_nxt = qau_pkg::ST_EMIT;
          end else begin
            state_nxt = qau_pkg::ST_MAC;
          end
        end
      end
      qau_pkg::ST_MAC:   if (mac_last) state_nxt = qau_pkg::ST_DRAIN;
      qau_pkg::ST_DRAIN: state_nxt = sq_mode ? qau_pkg::ST_SQSUM : qau_pkg::ST_ROUND;
      qau_pkg::ST_ROUND: state_nxt = qau_pkg::ST_EMIT;
      qau_pkg::ST_SQSUM: state_nxt = sq_sum[64] ? qau_pkg::ST_SQDONE : qau_pkg::ST_SQRT;
      qau_pkg::ST_SQRT:  if (cnt_r == 5'd31) state_nxt = qau_pkg::ST_SQDONE;
      qau_pkg::ST_SQDONE: begin
        if (item_r.op == qau_pkg::OP_UNIT || root_r == '0) begin
          state_nxt = qau_pkg::ST_EMIT;
        end else begin
          state_nxt = qau_pkg::ST_DIV;
        end
      end
      qau_pkg::ST_DIV:    if (cnt_r == 5'(FB - 1)) state_nxt = qau_pkg::ST_DIVRND;
      qau_pkg::ST_DIVRND: state_nxt = qau_pkg::ST_EMIT;
      qau_pkg::ST_EMIT: begin
        if (out_free) begin
          if (item_r.op == qau_pkg::OP_MAT && row_r != 2'd2) begin
            state_nxt = qau_pkg::ST_MAC;
          end else begin
            state_nxt = qau_pkg::ST_IDLE;
          end
        end
      end
      default: state_nxt = qau_pkg::ST_IDLE;
    endcase
  end

  // strobes
  always_comb begin
    q_pop = (state_r == qau_pkg::ST_IDLE) && q_valid;
    emit  = (state_r == qau_pkg::ST_EMIT) && out_free;
  end

  // per-lane product selection
  always_comb begin
    for (int l = 0; l < 4; l++) begin
      if (item_r.op == qau_pkg::OP_MAT) begin
        ctl[l] = qau_pkg::mat_ctl(4'(row_r) * 4'd3 + 4'(l), k_r);
        if (l == 3) begin
          ctl[l].en = 1'b0;
        end
      end else if (sq_mode) begin
        ctl[l].src1 = 3'(l);
        ctl[l].src2 = 3'(l);
        ctl[l].neg  = 1'b0;
        ctl[l].dbl  = 1'b0;
        ctl[l].en   = 1'b1;
      end else begin
        ctl[l] = qau_pkg::mul_ctl(2'(l), k_r, item_r.op == qau_pkg::OP_APPROX);
      end
    end
  end

  // result word
  always_comb begin
    logic [WB:0]          ab0, ab1, ab2, ab3;
    logic signed [WB+1:0] dw;
    logic signed [34:0]   dn;
    logic [WB+1:0]        adw;
    logic [34:0]          adn;
    ab0 = qau_pkg::abs_w(res_r[0]);
    ab1 = qau_pkg::abs_w(res_r[1]);
    ab2 = qau_pkg::abs_w(res_r[2]);
    ab3 = qau_pkg::abs_w(res_r[3]);
    dw  = $signed({1'b0, ab3}) - $signed({1'b0, qau_pkg::ONE_Q});
    adw = dw[WB+1] ? -dw : dw;
    dn  = $signed({2'b00, root_r}) - $signed(35'(qau_pkg::ONE_Q));
    adn = dn[34] ? -dn : dn;
    out_nxt = '0;
    out_nxt.last = 1'b1;
    unique case (item_r.op)
      qau_pkg::OP_MUL: begin
        out_nxt.res_a    = res_r[0];
        out_nxt.res_b    = res_r[1];
        out_nxt.res_c    = res_r[2];
        out_nxt.res_d    = res_r[3];
        out_nxt.sat_flag = sat_r;
      end
      qau_pkg::OP_MAT: begin
        out_nxt.res_a    = res_r[0];
        out_nxt.res_b    = res_r[1];
        out_nxt.res_c    = res_r[2];
        out_nxt.sat_flag = sat_r;
        out_nxt.last     = (row_r == 2'd2);
      end
      qau_pkg::OP_CONJ: begin
        // negating the most negative word clamps to the maximum
        out_nxt.res_a = (item_r.opnd[0] == qau_pkg::WORD_MIN) ? qau_pkg::WORD_MAX
                                                              : -item_r.opnd[0];
        out_nxt.res_b = (item_r.opnd[1] == qau_pkg::WORD_MIN) ? qau_pkg::WORD_MAX
                                                              : -item_r.opnd[1];
        out_nxt.res_c = (item_r.opnd[2] == qau_pkg::WORD_MIN) ? qau_pkg::WORD_MAX
                                                              : -item_r.opnd[2];
        out_nxt.res_d = item_r.opnd[3];
        out_nxt.sat_flag = (item_r.opnd[0] == qau_pkg::WORD_MIN)
                        || (item_r.opnd[1] == qau_pkg::WORD_MIN)
                        || (item_r.opnd[2] == qau_pkg::WORD_MIN);
      end
      qau_pkg::OP_NORM: begin
        if (root_r == '0) begin
          out_nxt.test_flag = 1'b1;
        end else begin
          out_nxt.res_a = res_r[0];
          out_nxt.res_b = res_r[1];
          out_nxt.res_c = res_r[2];
          out_nxt.res_d = res_r[3];
        end
      end
      qau_pkg::OP_APPROX: begin
        out_nxt.sat_flag  = sat_r;
        out_nxt.test_flag = (ab0 < (WB+1)'(tol)) && (ab1 < (WB+1)'(tol))
                         && (ab2 < (WB+1)'(tol)) && (adw < (WB+2)'(tol));
      end
      qau_pkg::OP_UNIT: out_nxt.test_flag = (adn < 35'(tol));
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= qau_pkg::ST_IDLE;
      mac_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      mac_vld_r <= (state_r == qau_pkg::ST_MAC);
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    logic signed [AB-1:0] term;
    qau_pkg::rnd_t        rr;
    logic [60:0]          dsh;
    logic                 rup;
    logic [FB:0]          qq;
    if (q_pop) begin
      item_r <= q_item;
      k_r    <= '0;
      row_r  <= '0;
    end

    // issue: one product per lane
    if (state_r == qau_pkg::ST_MAC) begin
      k_r         <= mac_last ? 2'd0 : k_r + 2'd1;
      mac_first_r <= (k_r == 2'd0);
      for (int l = 0; l < 4; l++) begin
        mac_ctl_r[l] <= ctl[l];
        prod_r[l]    <= item_r.opnd[ctl[l].src1] * item_r.opnd[ctl[l].src2];
      end
    end

    // accumulate
    if (mac_vld_r) begin
      for (int l = 0; l < 4; l++) begin
        term = AB'(prod_r[l]);
        if (mac_ctl_r[l].dbl) term = term <<< 1;
        if (mac_ctl_r[l].neg) term = -term;
        if (!mac_ctl_r[l].en) term = '0;
        acc_r[l] <= (mac_first_r ? '0 : acc_r[l]) + term;
      end
    end

    if (state_r == qau_pkg::ST_ROUND) begin
      sat_r <= 1'b0;
      for (int l = 0; l < 4; l++) begin
        rr = qau_pkg::rnd_sat(acc_r[l]);
        res_r[l] <= rr.val;
        if (l < 3 || item_r.op != qau_pkg::OP_MAT) begin
          if (rr.sat) sat_r <= 1'b1;
        end
      end
    end

    // square root, two radicand bits a step
    if (state_r == qau_pkg::ST_SQSUM) begin
      sq_s_r   <= sq_sum[63:0];
      sq_rem_r <= '0;
      root_r   <= sq_sum[64] ? (33'd1 << 32) : '0;
      cnt_r    <= '0;
    end
    if (state_r == qau_pkg::ST_SQRT) begin
      sq_s_r <= {sq_s_r[61:0], 2'b00};
      cnt_r  <= cnt_r + 5'd1;
      if (sq_shift >= sq_trial) begin
        sq_rem_r <= sq_shift - sq_trial;
        root_r   <= {root_r[31:0], 1'b1};
      end else begin
        sq_rem_r <= sq_shift;
        root_r   <= {root_r[31:0], 1'b0};
      end
    end

    // restoring divide of |c| * 2^FRAC by the norm, four lanes
    if (state_r == qau_pkg::ST_SQDONE) begin
      cnt_r <= '0;
      for (int l = 0; l < 4; l++) begin
        drem_r[l] <= 61'(qau_pkg::abs_w(item_r.opnd[l]));
        dq_r[l]   <= '0;
      end
    end
    if (state_r == qau_pkg::ST_DIV) begin
      cnt_r <= cnt_r + 5'd1;
      for (int l = 0; l < 4; l++) begin
        dsh = {drem_r[l][59:0], 1'b0};
        if (dsh >= 61'(root_r)) begin
          drem_r[l] <= dsh - 61'(root_r);
          dq_r[l]   <= {dq_r[l][FB-2:0], 1'b1};
        end else begin
          drem_r[l] <= dsh;
          dq_r[l]   <= {dq_r[l][FB-2:0], 1'b0};
        end
      end
    end
    if (state_r == qau_pkg::ST_DIVRND) begin
      for (int l = 0; l < 4; l++) begin
        rup = ({drem_r[l], 1'b0} >= 62'(root_r));
        qq  = (FB+1)'(dq_r[l]) + (FB+1)'(rup);
        res_r[l] <= item_r.opnd[l][WB-1] ? -WB'(qq) : WB'(qq);
      end
    end

    if (emit) begin
      out_r <= out_nxt;
      if (item_r.op == qau_pkg::OP_MAT) begin
        row_r <= row_r + 2'd1;
      end
    end
  end

endmodule

@@ hw/rtl/quaternion_arithmetic_unit_top.sv @@
`timescale 1ns / 1ps
// Channel | Ports                            | Word
// input   | in_valid in_ready in_data        | qau_pkg::in_word_t
// result  | out_valid out_ready out_data     | qau_pkg::out_word_t
// config  | cfg_we cfg_wdata                 | tolerance, 29 bits
// Back-end steps per request: conjugate goes straight to emit; product and
// approx test run 4 MAC steps, drain, round, emit; matrix runs three rows of
// those; unit test runs 32 square-root steps; normalize adds 28 divide steps in
// four lanes. The four-lane multiply-accumulate and the one result register set
// these steps. A two-entry queue lets the front take words while the back is busy.
// rst_n is synchronous; tolerance resets to 268.

module quaternion_arithmetic_unit_top #(
  parameter int QUEUE_DEPTH = qau_pkg::QUEUE_DEPTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  qau_pkg::in_word_t             in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output qau_pkg::out_word_t            out_data,
  input  logic                          cfg_we,
  input  logic [qau_pkg::TOL_BITS-1:0]  cfg_wdata
);

  logic [qau_pkg::TOL_BITS-1:0] tol_r;
  logic                         push_valid, push_ready;
  qau_pkg::item_t               push_item;
  logic                         q_valid, q_pop;
  qau_pkg::item_t               q_item;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= qau_pkg::TOL_RESET;
    end else if (cfg_we) begin
      tol_r <= cfg_wdata;
    end
  end

  qau_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  qau_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_item   (q_item)
  );

  qau_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_item    (q_item),
    .tol       (tol_r),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

@@ tb/qau_checker.sv @@
`timescale 1ns / 1ps

module qau_checker (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic                         in_ready,
  input  qau_pkg::in_word_t            in_data,
  input  logic                         out_valid,
  input  logic                         out_ready,
  input  qau_pkg::out_word_t           out_data,
  input  logic                         cfg_we,
  input  logic [qau_pkg::TOL_BITS-1:0] cfg_wdata,
  output int                           errors,
  output int                           pending
);

  typedef longint quat_t [4];

  localparam longint VMAX = 64'sd2147483647;
  localparam longint VMIN = -64'sd2147483648;
  localparam longint ONE  = 64'sd1 << qau_pkg::FRAC_BITS;

  // JPL product: lane r uses a[ai[r][k]] * b[k], negated where ng is set
  localparam int AI [4][4] = '{'{3,2,1,0}, '{2,3,0,1}, '{1,0,3,2}, '{0,1,2,3}};
  localparam int NG [4][4] = '{'{0,0,1,0}, '{1,0,0,0}, '{0,1,0,0}, '{1,1,1,0}};
  // matrix entry terms (i, j, sign); sign 2 marks an unused term
  localparam int MT [9][4][3] = '{
    '{'{0,0,0}, '{1,1,1}, '{2,2,1}, '{3,3,0}},
    '{'{0,1,0}, '{2,3,0}, '{0,0,2}, '{0,0,2}},
    '{'{0,2,0}, '{1,3,1}, '{0,0,2}, '{0,0,2}},
    '{'{0,1,0}, '{2,3,1}, '{0,0,2}, '{0,0,2}},
    '{'{0,0,1}, '{1,1,0}, '{2,2,1}, '{3,3,0}},
    '{'{1,2,0}, '{0,3,0}, '{0,0,2}, '{0,0,2}},
    '{'{0,2,0}, '{1,3,0}, '{0,0,2}, '{0,0,2}},
    '{'{1,2,0}, '{0,3,1}, '{0,0,2}, '{0,0,2}},
    '{'{0,0,1}, '{1,1,1}, '{2,2,0}, '{3,3,0}}};
  localparam int MDBL [9] = '{0,1,1,1,0,1,1,1,0};

  logic [qau_pkg::TOL_BITS-1:0] tolerance;
  qau_pkg::out_word_t           expected_words [$];

  function automatic longint round_sat(input logic signed [127:0] acc, inout bit sat);
    logic signed [127:0] t;
    t = (acc + (128'sd1 <<< (qau_pkg::FRAC_BITS - 1))) >>> qau_pkg::FRAC_BITS;
    if (t > VMAX) begin
      sat = 1'b1;
      return VMAX;
    end
    if (t < VMIN) begin
      sat = 1'b1;
      return VMIN;
    end
    return longint'(t);
  endfunction

  function automatic longint clamp_word(input longint v, inout bit sat);
    if (v > VMAX) begin
      sat = 1'b1;
      return VMAX;
    end
    if (v < VMIN) begin
      sat = 1'b1;
      return VMIN;
    end
    return v;
  endfunction

  function automatic longint mag(input longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic void jpl_product(input quat_t a, input quat_t b, output quat_t p,
                                      inout bit sat);
    logic signed [127:0] acc;
    longint              t;
    for (int r = 0; r < 4; r++) begin
      acc = '0;
      for (int k = 0; k < 4; k++) begin
        t = a[AI[r][k]] * b[k];
        acc = acc + (NG[r][k] != 0 ? -t : t);
      end
      p[r] = round_sat(acc, sat);
    end
  endfunction

  // floor of the square root of the exact sum of squares
  function automatic longint norm_of(input quat_t a);
    logic [127:0] s;
    logic [127:0] res;
    logic [127:0] cand;
    s = '0;
    for (int i = 0; i < 4; i++) s = s + 128'(a[i] * a[i]);
    res = '0;
    for (int b = 33; b >= 0; b--) begin
      cand = res | (128'd1 << b);
      if (cand * cand <= s) res = cand;
    end
    return longint'(res);
  endfunction

  function automatic qau_pkg::out_word_t pack_word(input quat_t v, input bit tst,
                                                   input bit sat, input bit fin);
    qau_pkg::out_word_t w;
    w.res_a     = qau_pkg::word_t'(v[0]);
    w.res_b     = qau_pkg::word_t'(v[1]);
    w.res_c     = qau_pkg::word_t'(v[2]);
    w.res_d     = qau_pkg::word_t'(v[3]);
    w.test_flag = tst;
    w.sat_flag  = sat;
    w.last      = fin;
    return w;
  endfunction

  task automatic predict_request(input qau_pkg::in_word_t req);
    quat_t               a, b, r, cb, q, v;
    bit                  sat, ok;
    longint              n, rem, quo, eps;
    logic signed [127:0] acc;
    a   = '{longint'(req.a_x), longint'(req.a_y), longint'(req.a_z), longint'(req.a_w)};
    b   = '{longint'(req.b_x), longint'(req.b_y), longint'(req.b_z), longint'(req.b_w)};
    r   = '{0, 0, 0, 0};
    sat = 1'b0;
    eps = longint'(tolerance);
    case (req.req_type)
      qau_pkg::REQ_MUL: begin
        jpl_product(a, b, r, sat);
        expected_words.push_back(pack_word(r, 1'b0, sat, 1'b1));
      end
      qau_pkg::REQ_CONJ: begin
        for (int i = 0; i < 3; i++) r[i] = clamp_word(-a[i], sat);
        r[3] = a[3];
        expected_words.push_back(pack_word(r, 1'b0, sat, 1'b1));
      end
      qau_pkg::REQ_NORM: begin
        n = norm_of(a);
        if (n == 0) begin
          expected_words.push_back(pack_word(r, 1'b1, 1'b0, 1'b1));
        end else begin
          for (int i = 0; i < 4; i++) begin
            quo = (mag(a[i]) << qau_pkg::FRAC_BITS) / n;
            rem = (mag(a[i]) << qau_pkg::FRAC_BITS) % n;
            if (2 * rem >= n) quo++;
            r[i] = clamp_word(a[i] < 0 ? -quo : quo, sat);
          end
          expected_words.push_back(pack_word(r, 1'b0, sat, 1'b1));
        end
      end
      qau_pkg::REQ_MAT: begin
        for (int row = 0; row < 3; row++) begin
          v   = '{0, 0, 0, 0};
          sat = 1'b0;
          for (int c = 0; c < 3; c++) begin
            acc = '0;
            for (int rep = 0; rep <= MDBL[row*3+c]; rep++)
              for (int k = 0; k < 4; k++)
                if (MT[row*3+c][k][2] != 2)
                  acc = acc + (MT[row*3+c][k][2] != 0 ?
                               -(a[MT[row*3+c][k][0]] * a[MT[row*3+c][k][1]]) :
                               a[MT[row*3+c][k][0]] * a[MT[row*3+c][k][1]]);
            v[c] = round_sat(acc, sat);
          end
          expected_words.push_back(pack_word(v, 1'b0, sat, row == 2));
        end
      end
      qau_pkg::REQ_APPROX: begin
        cb = '{-b[0], -b[1], -b[2], b[3]};
        jpl_product(a, cb, q, sat);
        ok = mag(q[0]) < eps && mag(q[1]) < eps && mag(q[2]) < eps &&
             mag(mag(q[3]) - ONE) < eps;
        expected_words.push_back(pack_word(r, ok, sat, 1'b1));
      end
      qau_pkg::REQ_UNIT: begin
        n = norm_of(a);
        expected_words.push_back(pack_word(r, mag(n - ONE) < eps, 1'b0, 1'b1));
      end
      default: expected_words.push_back(pack_word(r, 1'b0, 1'b0, 1'b1));
    endcase
  endtask

  task automatic report(input string field, input longint got, input longint want);
    $display("%0t: result %s is %0d, expected %0d", $realtime, field, got, want);
    errors++;
  endtask

  task automatic check_word(input qau_pkg::out_word_t got);
    qau_pkg::out_word_t want;
    if (expected_words.size() == 0) begin
      report("word without request", 1, 0);
      return;
    end
    want = expected_words.pop_front();
    if (got.res_a !== want.res_a) report("res_a", got.res_a, want.res_a);
    if (got.res_b !== want.res_b) report("res_b", got.res_b, want.res_b);
    if (got.res_c !== want.res_c) report("res_c", got.res_c, want.res_c);
    if (got.res_d !== want.res_d) report("res_d", got.res_d, want.res_d);
    if (got.test_flag !== want.test_flag) report("test_flag", got.test_flag, want.test_flag);
    if (got.sat_flag !== want.sat_flag) report("sat_flag", got.sat_flag, want.sat_flag);
    if (got.last !== want.last) report("last", got.last, want.last);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      tolerance <= qau_pkg::TOL_RESET;
    end else begin
      if (in_valid && in_ready) predict_request(in_data);
      if (out_valid && out_ready) check_word(out_data);
      if (cfg_we) tolerance <= cfg_wdata;
      pending = expected_words.size();
    end
  end

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps

module tb;

  // codes with no operation behind them
  localparam logic [2:0] REQ_SPARE6 = 3'd6;
  localparam logic [2:0] REQ_SPARE7 = 3'd7;
  localparam int         ONE_I      = 1 << qau_pkg::FRAC_BITS;
  localparam int         LIMIT      = 400000;
  localparam int         PER_PHASE  = 44;

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         in_valid = 1'b0;
  logic                         in_ready;
  qau_pkg::in_word_t            in_data = '0;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  qau_pkg::out_word_t           out_data;
  logic                         cfg_we = 1'b0;
  logic [qau_pkg::TOL_BITS-1:0] cfg_wdata = '0;
  int                           errors;
  int                           pending;
  int                           cycles = 0;
  bit                           quiet = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  quaternion_arithmetic_unit_top DUT (
    .clk, .rst_n, .in_valid, .in_ready, .in_data,
    .out_valid, .out_ready, .out_data, .cfg_we, .cfg_wdata
  );

  qau_checker u_checker (
    .clk, .rst_n, .in_valid, .in_ready, .in_data, .out_valid, .out_ready, .out_data,
    .cfg_we, .cfg_wdata, .errors, .pending
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("quaternion_arithmetic_unit_top: mismatch");
      $finish;
    end
  end

  // result side: random stall before each word
  initial begin
    int stall;
    @(posedge clk iff rst_n);
    forever begin
      stall = quiet ? 0 : $urandom_range(0, 10);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic send_request(input qau_pkg::in_word_t w);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
  endtask

  function automatic qau_pkg::in_word_t make_req(input logic [2:0] op, input int ax,
                                                 input int ay, input int az, input int aw,
                                                 input int bx, input int by, input int bz,
                                                 input int bw);
    qau_pkg::in_word_t w;
    w.req_type = op;
    w.a_x = ax; w.a_y = ay; w.a_z = az; w.a_w = aw;
    w.b_x = bx; w.b_y = by; w.b_z = bz; w.b_w = bw;
    return w;
  endfunction

  function automatic int rand_comp();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return int'($urandom_range(0, 1 << 30)) - (1 << 29);
      2: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      default: return int'($urandom_range(0, 64)) - 32;
    endcase
  endfunction

  // random rotation, Q3.28, with a small random error
  task automatic unit_quat(output int q[4]);
    real v[4];
    real s;
    s = 0.0;
    for (int i = 0; i < 4; i++) begin
      v[i] = real'($urandom_range(0, 2000)) - 1000.0;
      s += v[i] * v[i];
    end
    if (s == 0.0) begin
      v[3] = 1.0;
      s = 1.0;
    end
    s = $sqrt(s);
    for (int i = 0; i < 4; i++)
      q[i] = $rtoi(v[i] / s * ONE_I) + int'($urandom_range(0, 600)) - 300;
  endtask

  task automatic random_request();
    int                a[4], b[4];
    int                kind;
    qau_pkg::in_word_t w;
    kind = $urandom_range(0, 9);
    for (int i = 0; i < 4; i++) begin
      a[i] = rand_comp();
      b[i] = rand_comp();
    end
    if (kind >= 6) begin
      unit_quat(a);
      for (int i = 0; i < 4; i++)
        b[i] = (kind == 9 ? -a[i] : a[i]) + int'($urandom_range(0, 800)) - 400;
      if (kind == 6) unit_quat(b);
    end
    case (kind)
      6, 8, 9: w = make_req(qau_pkg::REQ_APPROX, a[0], a[1], a[2], a[3],
                            b[0], b[1], b[2], b[3]);
      7: w = make_req(qau_pkg::REQ_UNIT, a[0], a[1], a[2], a[3], b[0], b[1], b[2], b[3]);
      default: w = make_req(3'($urandom_range(0, 7)), a[0], a[1], a[2], a[3],
                            b[0], b[1], b[2], b[3]);
    endcase
    send_request(w);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_tolerance(input logic [qau_pkg::TOL_BITS-1:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    logic [qau_pkg::TOL_BITS-1:0] tols [5];
    int                           mx, mn;
    mx = 32'sh7fffffff;
    mn = 32'sh80000000;
    tols = '{'0, qau_pkg::TOL_BITS'(ONE_I), '1,
             qau_pkg::TOL_BITS'($urandom_range(0, 4096)), qau_pkg::TOL_RESET};
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed words at the reset tolerance
    send_request(make_req(qau_pkg::REQ_MUL, mx, mx, mx, mx, mx, mx, mx, mx));
    send_request(make_req(qau_pkg::REQ_MUL, mn, mn, mn, mn, mx, mn, mx, mn));
    send_request(make_req(qau_pkg::REQ_MUL, 0, 0, 0, ONE_I, 1, -1, 2, ONE_I));
    send_request(make_req(qau_pkg::REQ_CONJ, mn, mx, -1, mn, 0, 0, 0, 0));
    send_request(make_req(qau_pkg::REQ_CONJ, 5, -7, 0, 9, -1, -1, -1, -1));
    send_request(make_req(qau_pkg::REQ_NORM, 0, 0, 0, 0, mx, mx, mx, mx));
    send_request(make_req(qau_pkg::REQ_NORM, mn, mn, mn, mn, 0, 0, 0, 0));
    send_request(make_req(qau_pkg::REQ_NORM, mx, 0, 0, 0, 0, 0, 0, 0));
    send_request(make_req(qau_pkg::REQ_NORM, 1, -1, 1, -1, 0, 0, 0, 0));
    send_request(make_req(qau_pkg::REQ_MAT, 0, 0, 0, ONE_I, 0, 0, 0, 0));
    send_request(make_req(qau_pkg::REQ_MAT, mn, mx, mn, mx, 0, 0, 0, 0));
    send_request(make_req(qau_pkg::REQ_MAT, 123456789, -98765432, 55555555, 200000000,
                          0, 0, 0, 0));
    send_request(make_req(qau_pkg::REQ_APPROX, 0, 0, 0, ONE_I, 0, 0, 0, ONE_I));
    send_request(make_req(qau_pkg::REQ_APPROX, 0, 0, 0, ONE_I, 0, 0, 0, -ONE_I));
    send_request(make_req(qau_pkg::REQ_APPROX, 0, 0, 0, ONE_I, 300, 0, 0, ONE_I));
    send_request(make_req(qau_pkg::REQ_APPROX, mx, mn, mx, mn, mn, mx, mn, mx));
    send_request(make_req(qau_pkg::REQ_UNIT, 0, 0, 0, ONE_I, 0, 0, 0, 0));
    send_request(make_req(qau_pkg::REQ_UNIT, 0, 0, 0, ONE_I + 300, 0, 0, 0, 0));
    send_request(make_req(qau_pkg::REQ_UNIT, 0, 0, 0, 0, 0, 0, 0, 0));
    send_request(make_req(qau_pkg::REQ_UNIT, mn, mn, mn, mn, 0, 0, 0, 0));
    send_request(make_req(REQ_SPARE6, mx, mx, mx, mx, mx, mx, mx, mx));
    send_request(make_req(REQ_SPARE7, mn, mn, mn, mn, mn, mn, mn, mn));

    foreach (tols[p]) begin
      wait_idle();
      write_tolerance(tols[p]);
      quiet = (p == 2);
      repeat (PER_PHASE) random_request();
    end
    quiet = 1'b0;

    wait_idle();
    if (errors == 0) begin
      $display("quaternion_arithmetic_unit_top: match");
    end else begin
      $display("quaternion_arithmetic_unit_top: mismatch");
    end
    $finish;
  end

endmodule
